FILE: hw/rtl/v3n_pkg.sv
// v3n_pkg: shared constants for the vector normalize unit.
// No dependencies.
package v3n_pkg;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int UNIT_FRAC      = 30;
    localparam int UNIT_W         = 32;
    localparam int LEN_W          = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = 2;
endpackage

FILE: hw/rtl/v3n_front.sv
// v3n_front: takes magnitudes and signs of the components, flags zero vectors, queues them.
// Depends on v3n_pkg.
module v3n_front #(
    parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [3*COMP_WIDTH-1:0] in_data,
    output logic                    q_valid,
    input  logic                    q_ready,
    output logic [3*COMP_WIDTH+3:0] q_data
);
    import v3n_pkg::*;
    logic [COMP_WIDTH-1:0] comp [3];
    logic [COMP_WIDTH-1:0] mag  [3];
    logic [2:0] neg;
    logic [3*COMP_WIDTH+3:0] mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0] wp_reg, rp_reg;
    logic [3*COMP_WIDTH+3:0] entry;
    logic push, pop;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            comp[k] = in_data[k*COMP_WIDTH +: COMP_WIDTH];
            neg[k]  = comp[k][COMP_WIDTH-1];
            mag[k]  = neg[k] ? (~comp[k] + 1'b1) : comp[k];
        end
        entry = {(comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0), neg,
                 mag[2], mag[1], mag[0]};
    end

    assign in_ready = (wp_reg - rp_reg) != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign q_valid  = wp_reg != rp_reg;
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;
    assign q_data = mem_reg[rp_reg[QUEUE_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg[QUEUE_AW-1:0]] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
        end
    end
endmodule

FILE: hw/rtl/v3n_back.sv
// v3n_back: pipelined sum of squares, square root and three divides.
// Depends on v3n_pkg.
module v3n_back #(
    parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  logic [3*COMP_WIDTH+3:0] q_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3*v3n_pkg::UNIT_W+v3n_pkg::LEN_W:0] out_data
);
    import v3n_pkg::*;
    localparam int CW   = COMP_WIDTH;
    localparam int SW   = 2*CW + 2;
    localparam int RW   = CW + 1;
    localparam int NSQ  = SW / 2;
    localparam int NDIV = UNIT_FRAC + 2;
    localparam int QW   = NDIV;
    localparam int DW   = RW + 1;
    localparam int NST  = 1 + NSQ + NDIV + 1;

    logic advance;
    logic v_reg [NST];

    // stage 0: squares
    logic [CW-1:0] m0_reg [3];
    logic [2:0]    n0_reg;
    logic          z0_reg;
    logic [2*CW-1:0] sq0_reg [3];

    // sqrt stages
    logic [SW-1:0] sv_reg  [NSQ+1];
    logic [RW+1:0] rem_reg [NSQ+1];
    logic [RW-1:0] root_reg[NSQ+1];
    logic [CW-1:0] sm_reg  [NSQ+1][3];
    logic [2:0]    sn_reg  [NSQ+1];
    logic          sz_reg  [NSQ+1];

    // divide stages
    logic [DW-1:0] dr_reg [NDIV][3];
    logic [QW-1:0] dq_reg [NDIV][3];
    logic [RW-1:0] dl_reg [NDIV];
    logic [2:0]    dn_reg [NDIV];
    logic          dz_reg [NDIV];

    logic [3*UNIT_W+LEN_W:0] res_reg;
    logic                    res_v_reg;

    assign advance  = !res_v_reg || out_ready;
    assign q_ready  = advance;
    assign out_valid = res_v_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++) v_reg[i] <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= q_valid;
            for (int i = 1; i < NST; i++) v_reg[i] <= v_reg[i-1];
            res_v_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // squares
            for (int k = 0; k < 3; k++)
            begin
                m0_reg[k]  <= q_data[k*CW +: CW];
                sq0_reg[k] <= q_data[k*CW +: CW] * q_data[k*CW +: CW];
            end
            n0_reg <= q_data[3*CW +: 3];
            z0_reg <= q_data[3*CW+3];
            // sum
            sv_reg[0]   <= SW'(sq0_reg[0]) + SW'(sq0_reg[1]) + SW'(sq0_reg[2]);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int k = 0; k < 3; k++) sm_reg[0][k] <= m0_reg[k];
            sn_reg[0] <= n0_reg;
            sz_reg[0] <= z0_reg;
            // one root bit per stage
            for (int i = 0; i < NSQ; i++)
            begin
                logic [RW+1:0] r;
                logic [RW+1:0] t;
                r = {rem_reg[i][RW-1:0], sv_reg[i][SW-1 -: 2]};
                t = {root_reg[i], 2'b01};
                sv_reg[i+1] <= {sv_reg[i][SW-3:0], 2'b00};
                if (r >= t)
                begin
                    rem_reg[i+1]  <= r - t;
                    root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1]  <= r;
                    root_reg[i+1] <= {root_reg[i][RW-2:0], 1'b0};
                end
                for (int k = 0; k < 3; k++) sm_reg[i+1][k] <= sm_reg[i][k];
                sn_reg[i+1] <= sn_reg[i];
                sz_reg[i+1] <= sz_reg[i];
            end
            // divide setup: first quotient bit
            for (int k = 0; k < 3; k++)
            begin
                logic [DW-1:0] r0;
                r0 = DW'(sm_reg[NSQ][k]);
                if (r0 >= DW'(root_reg[NSQ]))
                begin
                    dr_reg[0][k] <= r0 - DW'(root_reg[NSQ]);
                    dq_reg[0][k] <= QW'(1);
                end
                else
                begin
                    dr_reg[0][k] <= r0;
                    dq_reg[0][k] <= '0;
                end
            end
            dl_reg[0] <= root_reg[NSQ];
            dn_reg[0] <= sn_reg[NSQ];
            dz_reg[0] <= sz_reg[NSQ];
            for (int i = 0; i < NDIV - 1; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [DW-1:0] r;
                    r = {dr_reg[i][k][DW-2:0], 1'b0};
                    if (r >= DW'(dl_reg[i]))
                    begin
                        dr_reg[i+1][k] <= r - DW'(dl_reg[i]);
                        dq_reg[i+1][k] <= {dq_reg[i][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[i+1][k] <= r;
                        dq_reg[i+1][k] <= {dq_reg[i][k][QW-2:0], 1'b0};
                    end
                end
                dl_reg[i+1] <= dl_reg[i];
                dn_reg[i+1] <= dn_reg[i];
                dz_reg[i+1] <= dz_reg[i];
            end
            // round, sign, pack
            for (int k = 0; k < 3; k++)
            begin
                logic [QW-1:0] u;
                u = (dq_reg[NDIV-1][k] + 1'b1) >> 1;
                if (dz_reg[NDIV-1])
                    res_reg[k*UNIT_W +: UNIT_W] <= '0;
                else if (dn_reg[NDIV-1][k])
                    res_reg[k*UNIT_W +: UNIT_W] <= UNIT_W'(~u + 1'b1);
                else
                    res_reg[k*UNIT_W +: UNIT_W] <= UNIT_W'(u);
            end
            res_reg[3*UNIT_W +: LEN_W] <= LEN_W'(dl_reg[NDIV-1]);
            res_reg[3*UNIT_W+LEN_W]    <= dz_reg[NDIV-1];
        end
    end
endmodule

FILE: hw/rtl/vector3_normalize_unit.sv
// vector3_normalize_unit: top level, front classifier, queue, arithmetic back end.
// Depends on v3n_pkg, v3n_front, v3n_back.
// One vector is accepted per cycle while the queue has room. From input
// accept to output valid a vector passes the queue slot, the squares and
// sum stages, the bit-per-stage square root (COMP_WIDTH+1 stages), the
// 32-stage restoring divides and the output register.
// A 4-entry queue between front and back absorbs output stalls.
module vector3_normalize_unit #(
    parameter int COMP_WIDTH = v3n_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = v3n_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // comp_x, comp_y, comp_z (low to high), zero padded to bytes
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // unit_x, unit_y, unit_z, vec_length (low to high)
    output logic [127:0]            m_tdata,
    // zero_vector
    output logic                    m_tuser
);
    import v3n_pkg::*;
    logic                    q_valid, q_ready;
    logic [3*COMP_WIDTH+3:0] q_data;
    logic [3*UNIT_W+LEN_W:0] res;

    v3n_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_data(s_tdata[3*COMP_WIDTH-1:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    v3n_back #(.COMP_WIDTH(COMP_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = res[127:0];
    assign m_tuser = res[128];
endmodule

FILE: hw/rtl/v3n_checker.sv
// v3n_checker: port-level assertions for vector3_normalize_unit, with bind.
// Depends on vector3_normalize_unit.
module v3n_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector with nonzero data");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[127:96] != 32'd0)
        else $error("nonzero vector with zero length");
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[31:0] != 32'h8000_0000)
        else $error("unit out of range");
endmodule

bind vector3_normalize_unit v3n_checker u_v3n_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
